FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants of the sorted priority queue
// Status codes, request type codes, payload width, parameter defaults and the cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int DEF_DEPTH     = 16;
    localparam int DEF_PRIO_W    = 16;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ENQ   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQ   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // request type codes
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_core.sv
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless a result waits; the cell chain inserts or removes in
// a single step whatever the fill level, and the output register is free again as soon
// as its result is taken. Reset (synchronous, active low) empties the queue
// and clears the output valid; slot contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue_core - sorted-list priority queue
// A chain of DEPTH cells kept in priority order; enqueue inserts behind every
// entry of greater or equal priority, dequeue removes the head.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int PRIO_WIDTH = DEF_PRIO_W,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire                         i_req_type,
    input  wire        [DATA_W-1:0]     i_data_in,
    input  wire signed [PRIO_WIDTH-1:0] i_prio_in,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic       [STATUS_W-1:0]   o_status,
    output logic       [DATA_W-1:0]     o_data_out,
    output logic       [CNT_W-1:0]      o_fill_count
);

    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_data_out, n_data_out;

    logic                w_accept, w_full, w_empty;
    t_cell_ctrl          w_ctrl;

    logic                         w_ge   [DEPTH];
    logic        [DATA_W-1:0]     w_data [DEPTH];
    logic signed [PRIO_WIDTH-1:0] w_prio [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // issue the command to the chain
    always_comb begin
        w_ctrl.enq = w_accept && (i_req_type == REQ_ENQ) && !w_full;
        w_ctrl.deq = w_accept && (i_req_type == REQ_DEQ) && !w_empty;
    end

    // build the chain of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                         w_left_ge;
        logic        [DATA_W-1:0]     w_left_data, w_right_data;
        logic signed [PRIO_WIDTH-1:0] w_left_prio, w_right_prio;

        if (g == 0) begin : g_head
            assign w_left_ge   = 1'b1;
            assign w_left_data = i_data_in;
            assign w_left_prio = i_prio_in;
        end else begin : g_mid
            assign w_left_ge   = w_ge[g-1];
            assign w_left_data = w_data[g-1];
            assign w_left_prio = w_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_data = w_data[g];
            assign w_right_prio = w_prio[g];
        end else begin : g_body
            assign w_right_data = w_data[g+1];
            assign w_right_prio = w_prio[g+1];
        end

        spq_cell #(
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_new_data   (i_data_in),
            .i_new_prio   (i_prio_in),
            .i_left_ge    (w_left_ge),
            .i_left_data  (w_left_data),
            .i_left_prio  (w_left_prio),
            .i_right_data (w_right_data),
            .i_right_prio (w_right_prio),
            .o_ge         (w_ge[g]),
            .o_data       (w_data[g]),
            .o_prio       (w_prio[g])
        );
    end

    // form the result and the next fill level
    always_comb begin
        n_count    = r_count;
        n_status   = ST_ENQ;
        n_data_out = '0;
        if (i_req_type == REQ_ENQ) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count  = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status   = ST_EMPTY;
                n_data_out = '1;
            end else begin
                n_status   = ST_DEQ;
                n_data_out = w_data[0];
                n_count    = r_count - CNT_W'(1);
            end
        end
    end

    // hold fill level and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_data_out <= n_data_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_data_out   = r_data_out;
    assign o_fill_count = r_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill level beyond depth");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.enq |=> (r_count == $past(r_count) + CNT_W'(1)) && (o_status == ST_ENQ))
        else $error("enqueue did not grow the queue");

    a_deq_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.deq |=> (o_data_out == $past(w_data[0])) && (o_status == ST_DEQ))
        else $error("dequeue did not return the head entry");

    a_empty_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (o_data_out == '1))
        else $error("empty dequeue without all-ones data");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted chain
// Holds one entry, compares it with the incoming priority and shifts right
// on an insert below it or left on a head removal.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIO_WIDTH = DEF_PRIO_W
) (
    input  wire                         i_clk,
    input  wire t_cell_ctrl             i_ctrl,
    input  wire                         i_occupied,
    input  wire        [DATA_W-1:0]     i_new_data,
    input  wire signed [PRIO_WIDTH-1:0] i_new_prio,
    input  wire                         i_left_ge,
    input  wire        [DATA_W-1:0]     i_left_data,
    input  wire signed [PRIO_WIDTH-1:0] i_left_prio,
    input  wire        [DATA_W-1:0]     i_right_data,
    input  wire signed [PRIO_WIDTH-1:0] i_right_prio,
    output logic                        o_ge,
    output logic       [DATA_W-1:0]     o_data,
    output logic signed [PRIO_WIDTH-1:0] o_prio
);

    logic        [DATA_W-1:0]     r_data, n_data;
    logic signed [PRIO_WIDTH-1:0] r_prio, n_prio;

    // entry stays ahead of the new one when it is held and not lower
    assign o_ge   = i_occupied && (r_prio >= i_new_prio);
    assign o_data = r_data;
    assign o_prio = r_prio;

    // pick the next content: keep, take new, shift from left or right
    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctrl.deq) begin
            n_data = i_right_data;
            n_prio = i_right_prio;
        end else if (i_ctrl.enq && !o_ge) begin
            if (i_left_ge) begin
                n_data = i_new_data;
                n_prio = i_new_prio;
            end else begin
                n_data = i_left_data;
                n_prio = i_left_prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

endmodule

`default_nettype wire
